>>> src/pq_rgb_pixel_tonemap_top_macros.svh
// assertion helpers for the tonemap pipeline
`ifndef PQ_RGB_PIXEL_TONEMAP_TOP_MACROS_SVH
`define PQ_RGB_PIXEL_TONEMAP_TOP_MACROS_SVH

// same-cycle implication
`define PQTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pqtm same-cycle check failed");

// next-cycle implication
`define PQTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pqtm next-cycle check failed");

`endif

>>> src/pqtm_pkg.sv
`default_nettype none
package pqtm_pkg;

    // item commands
    typedef enum logic [1:0] {
        CMD_PIXEL      = 2'd0,
        CMD_LOAD_PQ    = 2'd1,
        CMD_LOAD_BAKED = 2'd2,
        CMD_LOAD_SRGB  = 2'd3
    } pqtm_cmd_t;

    // register indexes
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_PAPER  = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_CHROMA = 2'd3;

    // table geometry
    localparam int PQ_DEPTH   = 256;
    localparam int BK_DEPTH   = 4096;
    localparam int SRGB_DEPTH = 1024;

    // fixed constants
    localparam logic [6:0]  BAKED_TARGET = 7'd58;
    localparam logic [13:0] BAKED_PAPER  = 14'd203;
    localparam logic [17:0] SCALE_CAP    = 18'h30000;
    localparam logic [17:0] RECIP_100    = 18'd167773;  // ceil(2^24 / 100)
    localparam logic [10:0] LUMA_R       = 11'd689;
    localparam logic [10:0] LUMA_G       = 11'd1778;
    localparam logic [10:0] LUMA_B       = 11'd155;

    // divider geometry
    localparam int DA_LANES = 5;
    localparam int DA_NUM_W = 38;
    localparam int DA_DEN_W = 21;
    localparam int DA_Q_W   = 30;
    localparam int DB_NUM_W = 32;
    localparam int DB_DEN_W = 30;
    localparam int DB_Q_W   = 32;

    typedef struct packed {
        pqtm_cmd_t   cmd;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
        logic        frame_end;
        logic [11:0] table_index;
        logic [25:0] table_value;
    } pqtm_pixel_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       frame_end_out;
    } pqtm_sdr_t;

    // sideband ahead of the luma stage
    typedef struct packed {
        logic        pix;
        logic        frame_end;
        logic        bk_we;
        logic        srgb_we;
        logic [11:0] tidx;
        logic [15:0] tval;
    } pqtm_early_t;

    // sideband after the luma stage
    typedef struct packed {
        logic       pix;
        logic       frame_end;
        logic       zero;
        logic       srgb_we;
        logic [9:0] srgb_idx;
        logic [7:0] srgb_val;
    } pqtm_misc_t;

    typedef struct packed {
        pqtm_misc_t  misc;
        logic        bake;
        logic [15:0] bk_val;
    } pqtm_a_side_t;

    typedef struct packed {
        pqtm_misc_t       misc;
        logic [2:0][29:0] rel;
    } pqtm_b_side_t;

endpackage
`default_nettype wire

>>> src/pqtm_div_pipe.sv
`default_nettype none
// pipelined restoring divider, two quotient bits per stage, Q_W even,
// requires num < den << Q_W and NUM_W <= DEN_W + Q_W
module pqtm_div_pipe #(
    parameter int NUM_W  = 38,
    parameter int DEN_W  = 21,
    parameter int Q_W    = 30,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]      num,
    input  wire logic [LANES-1:0][DEN_W-1:0]      den,
    input  wire logic [SIDE_W-1:0]                side_in,
    output logic                                  out_valid,
    output logic [LANES-1:0][Q_W-1:0]             quo,
    output logic [SIDE_W-1:0]                     side_out
);

    localparam int ST = Q_W / 2;
    localparam int CW = DEN_W + Q_W;

    logic [ST-1:0]                 valid_reg;
    logic [LANES-1:0][NUM_W-1:0]   rem_reg  [ST];
    logic [LANES-1:0][DEN_W-1:0]   den_reg  [ST];
    logic [LANES-1:0][Q_W-1:0]     quo_reg  [ST];
    logic [SIDE_W-1:0]             side_reg [ST];

    genvar s;
    for (s = 0; s < ST; s++) begin : g_stage
        localparam int HI = Q_W - 1 - 2 * s;

        logic                        valid_cur;
        logic [LANES-1:0][NUM_W-1:0] rem_cur;
        logic [LANES-1:0][NUM_W-1:0] rem_next;
        logic [LANES-1:0][DEN_W-1:0] den_cur;
        logic [LANES-1:0][Q_W-1:0]   quo_cur;
        logic [LANES-1:0][Q_W-1:0]   quo_next;
        logic [SIDE_W-1:0]           side_cur;

        // stage input select
        if (s == 0) begin : g_head
            assign valid_cur = in_valid;
            assign rem_cur   = num;
            assign den_cur   = den;
            assign quo_cur   = '0;
            assign side_cur  = side_in;
        end else begin : g_body
            assign valid_cur = valid_reg[s-1];
            assign rem_cur   = rem_reg[s-1];
            assign den_cur   = den_reg[s-1];
            assign quo_cur   = quo_reg[s-1];
            assign side_cur  = side_reg[s-1];
        end

        // two compare and subtract steps per lane
        always_comb
        begin
            logic [CW-1:0] r;
            logic [CW-1:0] d;
            rem_next = rem_cur;
            quo_next = quo_cur;
            for (int l = 0; l < LANES; l++)
            begin
                r = CW'(rem_cur[l]);
                d = CW'(den_cur[l]) << HI;
                if (r >= d)
                begin
                    r = r - d;
                    quo_next[l][HI] = 1'b1;
                end
                d = CW'(den_cur[l]) << (HI - 1);
                if (r >= d)
                begin
                    r = r - d;
                    quo_next[l][HI-1] = 1'b1;
                end
                rem_next[l] = r[NUM_W-1:0];
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_cur;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_cur;
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[ST-1];
    assign quo       = quo_reg[ST-1];
    assign side_out  = side_reg[ST-1];

endmodule
`default_nettype wire

>>> src/pq_rgb_pixel_tonemap_top.sv
`default_nettype none
// channel   handshake                 payload
// pixel     pixel_valid/pixel_ready   pqtm_pkg::pqtm_pixel_t
// sdr       sdr_valid/sdr_ready       pqtm_pkg::pqtm_sdr_t
// config    psel/penable/pwrite       paddr[3:2] selects, pwdata/prdata
//
// one item per cycle unless a stalled result holds the pipeline; a pixel result passes
// through the two pipelined dividers (15 and 16 stages, two bits each)
// a stalled result freezes the whole pipeline; pixel_ready is high while no result waits or sdr_ready is high
// reset clears valid bits and sets config registers to their defaults; tables hold nothing until loaded
// table loads travel the pipeline and write at the stage that reads that table
`include "pq_rgb_pixel_tonemap_top_macros.svh"
module pq_rgb_pixel_tonemap_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pixel_valid,
    output logic                       pixel_ready,
    input  wire pqtm_pkg::pqtm_pixel_t pixel,
    output logic                       sdr_valid,
    input  wire logic                  sdr_ready,
    output pqtm_pkg::pqtm_sdr_t        sdr,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // config registers
    logic [6:0]  target_reg;
    logic [13:0] paper_reg;
    logic [7:0]  gain_reg;
    logic [8:0]  chroma_reg;
    logic [6:0]  target_eff;
    logic [13:0] paper_eff;
    logic [7:0]  gain_eff;
    logic [8:0]  chroma_eff;

    logic adv;

    // memories
    logic [25:0] pq_mem_b [pqtm_pkg::PQ_DEPTH];
    logic [25:0] pq_mem_g [pqtm_pkg::PQ_DEPTH];
    logic [25:0] pq_mem_r [pqtm_pkg::PQ_DEPTH];
    logic [15:0] bk_mem   [pqtm_pkg::BK_DEPTH];
    logic [7:0]  srgb_mem [3][pqtm_pkg::SRGB_DEPTH];

    // stage registers
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                  s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic                  s9_valid_reg, s10_valid_reg, s11_valid_reg, s12_valid_reg;
    logic                  s13_valid_reg;
    pqtm_pkg::pqtm_early_t s1_early_reg, s2_early_reg, s3_early_reg;
    pqtm_pkg::pqtm_early_t s1_early_next;
    logic [25:0]           s1_nq_reg [3];
    logic [36:0]           s2_prod_reg [3];
    logic [2:0][13:0]      s2_nq14_reg, s3_nq14_reg, s4_nq14_reg;
    logic [13:0]           s3_y_reg;
    logic [13:0]           s4_yc_reg;
    logic [20:0]           s4_tprod_reg;
    logic                  s4_bake_reg;
    logic [15:0]           bk_rd_reg;
    pqtm_pkg::pqtm_misc_t  s4_misc_reg;
    logic [15:0]           s5_yout_reg;
    logic [29:0]           s5_yrel_reg;
    pqtm_pkg::pqtm_b_side_t s5_side_reg;
    logic [17:0]           s6_scale_reg;
    pqtm_pkg::pqtm_b_side_t s6_side_reg;
    logic [47:0]           s7_lp_reg [3];
    pqtm_pkg::pqtm_misc_t  s7_misc_reg, s8_misc_reg, s9_misc_reg;
    logic [7:0]            srgb_rd_reg [3];
    logic [15:0]           s9_gp_reg [3];
    logic [7:0]            s10_res_reg [3];
    logic                  s10_fe_reg, s11_fe_reg, s12_fe_reg;
    logic [7:0]            s11_res_reg [3];
    logic [7:0]            s11_yl_reg, s12_yl_reg;
    logic signed [17:0]    s12_d_reg [3];
    logic                  s12_pix_reg, s11_pix_reg, s10_pix_reg;
    pqtm_pkg::pqtm_sdr_t   s13_sdr_reg;

    // combinational stage values
    logic [37:0]           s3_sum;
    logic [11:0]           s4_ybk;
    logic [13:0]           s4_yc_next;
    logic                  s4_bake_next;
    pqtm_pkg::pqtm_misc_t  s4_misc_next;
    logic [9:0]            s8_idx [3];
    logic [7:0]            s10_res_next [3];
    logic [7:0]            s11_yl_next;
    logic signed [17:0]    s12_d_next [3];
    logic [7:0]            s13_ch_next [3];

    // divider wiring
    logic [pqtm_pkg::DA_LANES-1:0][pqtm_pkg::DA_NUM_W-1:0] da_num;
    logic [pqtm_pkg::DA_LANES-1:0][pqtm_pkg::DA_DEN_W-1:0] da_den;
    logic [pqtm_pkg::DA_LANES-1:0][pqtm_pkg::DA_Q_W-1:0]   da_quo;
    pqtm_pkg::pqtm_a_side_t da_side_in, da_side_out;
    logic                   da_out_valid;
    logic [14:0]            da_den_sum;
    logic [0:0][pqtm_pkg::DB_NUM_W-1:0] db_num;
    logic [0:0][pqtm_pkg::DB_DEN_W-1:0] db_den;
    logic [0:0][pqtm_pkg::DB_Q_W-1:0]   db_quo;
    pqtm_pkg::pqtm_b_side_t db_side_out;
    logic                   db_out_valid;
    logic [15:0]            s5_yout_next;
    logic [29:0]            s5_yrel_next;
    pqtm_pkg::pqtm_b_side_t s5_side_next;

    // effective register values
    always_comb
    begin
        target_eff = (target_reg == 7'd0) ? 7'd1 : ((target_reg > 7'd100) ? 7'd100 : target_reg);
        paper_eff  = (paper_reg == 14'd0) ? 14'd1
                   : ((paper_reg > 14'd10000) ? 14'd10000 : paper_reg);
        gain_eff   = (gain_reg == 8'd0) ? 8'd1 : ((gain_reg > 8'd200) ? 8'd200 : gain_reg);
        chroma_eff = (chroma_reg > 9'd300) ? 9'd300 : chroma_reg;
    end

    // config write
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 7'd50;
            paper_reg  <= 14'd400;
            gain_reg   <= 8'd150;
            chroma_reg <= 9'd150;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                pqtm_pkg::REG_TARGET: target_reg <= pwdata[6:0];
                pqtm_pkg::REG_PAPER:  paper_reg  <= pwdata[13:0];
                pqtm_pkg::REG_GAIN:   gain_reg   <= pwdata[7:0];
                pqtm_pkg::REG_CHROMA: chroma_reg <= pwdata[8:0];
            endcase
        end
    end

    // config read
    always_comb
    begin
        unique case (paddr[3:2])
            pqtm_pkg::REG_TARGET: prdata = 32'(target_reg);
            pqtm_pkg::REG_PAPER:  prdata = 32'(paper_reg);
            pqtm_pkg::REG_GAIN:   prdata = 32'(gain_reg);
            pqtm_pkg::REG_CHROMA: prdata = 32'(chroma_reg);
        endcase
    end

    // global advance
    assign adv         = !s13_valid_reg || sdr_ready;
    assign pixel_ready = adv;
    assign sdr_valid   = s13_valid_reg;
    assign sdr         = s13_sdr_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pixel_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= da_out_valid;
            s6_valid_reg  <= db_out_valid;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg && s12_pix_reg;
        end
    end

    // sideband for an accepted transaction
    always_comb
    begin
        s1_early_next.pix       = (pixel.cmd == pqtm_pkg::CMD_PIXEL);
        s1_early_next.frame_end = pixel.frame_end;
        s1_early_next.bk_we     = (pixel.cmd == pqtm_pkg::CMD_LOAD_BAKED);
        s1_early_next.srgb_we   = (pixel.cmd == pqtm_pkg::CMD_LOAD_SRGB)
                                  && (pixel.table_index[11:10] == 2'd0);
        s1_early_next.tidx      = pixel.table_index;
        s1_early_next.tval      = pixel.table_value[15:0];
    end

    // pq table copies, one per channel
    always_ff @(posedge clk)
    begin
        if (adv && pixel_valid && (pixel.cmd == pqtm_pkg::CMD_LOAD_PQ)
            && (pixel.table_index[11:8] == 4'd0))
        begin
            pq_mem_b[pixel.table_index[7:0]] <= pixel.table_value;
            pq_mem_g[pixel.table_index[7:0]] <= pixel.table_value;
            pq_mem_r[pixel.table_index[7:0]] <= pixel.table_value;
        end
        if (adv)
        begin
            s1_nq_reg[0] <= pq_mem_b[pixel.blue_in];
            s1_nq_reg[1] <= pq_mem_g[pixel.green_in];
            s1_nq_reg[2] <= pq_mem_r[pixel.red_in];
        end
    end

    // luma front stages
    assign s3_sum = 38'(s2_prod_reg[0]) + 38'(s2_prod_reg[1]) + 38'(s2_prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_early_reg   <= s1_early_next;
            s2_prod_reg[0] <= 37'(s1_nq_reg[0]) * 37'(pqtm_pkg::LUMA_B);
            s2_prod_reg[1] <= 37'(s1_nq_reg[1]) * 37'(pqtm_pkg::LUMA_G);
            s2_prod_reg[2] <= 37'(s1_nq_reg[2]) * 37'(pqtm_pkg::LUMA_R);
            for (int i = 0; i < 3; i++)
            begin
                s2_nq14_reg[i] <= s1_nq_reg[i][25:12];
            end
            s2_early_reg   <= s1_early_reg;
            s3_y_reg       <= s3_sum[37:24];
            s3_nq14_reg    <= s2_nq14_reg;
            s3_early_reg   <= s2_early_reg;
        end
    end

    // curve select and luma caps
    always_comb
    begin
        s4_bake_next = (target_eff == pqtm_pkg::BAKED_TARGET)
                       && (paper_eff == pqtm_pkg::BAKED_PAPER);
        s4_ybk       = (s3_y_reg > 14'd4095) ? 12'hFFF : s3_y_reg[11:0];
        if (s4_bake_next)
        begin
            s4_yc_next = 14'(s4_ybk);
        end
        else
        begin
            s4_yc_next = (s3_y_reg > 14'd10000) ? 14'd10000 : s3_y_reg;
        end
        s4_misc_next.pix       = s3_early_reg.pix;
        s4_misc_next.frame_end = s3_early_reg.frame_end;
        s4_misc_next.zero      = (s3_y_reg == 14'd0);
        s4_misc_next.srgb_we   = s3_early_reg.srgb_we;
        s4_misc_next.srgb_idx  = s3_early_reg.tidx[9:0];
        s4_misc_next.srgb_val  = s3_early_reg.tval[7:0];
    end

    // baked curve table
    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg && s3_early_reg.bk_we)
        begin
            bk_mem[s3_early_reg.tidx] <= s3_early_reg.tval;
        end
        if (adv)
        begin
            bk_rd_reg <= bk_mem[s4_ybk];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_yc_reg    <= s4_yc_next;
            s4_tprod_reg <= 21'(target_eff) * 21'(s4_yc_next);
            s4_bake_reg  <= s4_bake_next;
            s4_nq14_reg  <= s3_nq14_reg;
            s4_misc_reg  <= s4_misc_next;
        end
    end

    // first divider: live curve, relative luma, relative channels
    always_comb
    begin
        da_den_sum = 15'(s4_yc_reg) + 15'(paper_eff);
        da_num[0]  = (38'(s4_tprod_reg) << 17) - (38'(s4_tprod_reg) << 1);
        da_den[0]  = 21'(da_den_sum) * 21'(100);
        da_num[1]  = 38'({s4_yc_reg, 16'h0000});
        da_den[1]  = 21'(paper_eff);
        for (int i = 0; i < 3; i++)
        begin
            da_num[2+i] = 38'({s4_nq14_reg[i], 16'h0000});
            da_den[2+i] = 21'(paper_eff);
        end
        da_side_in.misc   = s4_misc_reg;
        da_side_in.bake   = s4_bake_reg;
        da_side_in.bk_val = bk_rd_reg;
    end

    pqtm_div_pipe #(
        .NUM_W  (pqtm_pkg::DA_NUM_W),
        .DEN_W  (pqtm_pkg::DA_DEN_W),
        .Q_W    (pqtm_pkg::DA_Q_W),
        .LANES  (pqtm_pkg::DA_LANES),
        .SIDE_W ($bits(pqtm_pkg::pqtm_a_side_t))
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .num       (da_num),
        .den       (da_den),
        .side_in   (da_side_in),
        .out_valid (da_out_valid),
        .quo       (da_quo),
        .side_out  (da_side_out)
    );

    // curve output and relative luma
    always_comb
    begin
        if (da_side_out.bake)
        begin
            s5_yout_next = da_side_out.bk_val;
        end
        else
        begin
            s5_yout_next = (da_quo[0] > 30'd65535) ? 16'hFFFF : da_quo[0][15:0];
        end
        s5_yrel_next      = (da_quo[1] == 30'd0) ? 30'd1 : da_quo[1];
        s5_side_next.misc = da_side_out.misc;
        for (int i = 0; i < 3; i++)
        begin
            s5_side_next.rel[i] = da_quo[2+i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_yout_reg <= s5_yout_next;
            s5_yrel_reg <= s5_yrel_next;
            s5_side_reg <= s5_side_next;
        end
    end

    // second divider: scale
    assign db_num[0] = {s5_yout_reg, 16'h0000};
    assign db_den[0] = s5_yrel_reg;

    pqtm_div_pipe #(
        .NUM_W  (pqtm_pkg::DB_NUM_W),
        .DEN_W  (pqtm_pkg::DB_DEN_W),
        .Q_W    (pqtm_pkg::DB_Q_W),
        .LANES  (1),
        .SIDE_W ($bits(pqtm_pkg::pqtm_b_side_t))
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s5_valid_reg),
        .num       (db_num),
        .den       (db_den),
        .side_in   (s5_side_reg),
        .out_valid (db_out_valid),
        .quo       (db_quo),
        .side_out  (db_side_out)
    );

    // scale cap and channel products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_scale_reg <= (db_quo[0] > 32'(pqtm_pkg::SCALE_CAP))
                            ? pqtm_pkg::SCALE_CAP : db_quo[0][17:0];
            s6_side_reg  <= db_side_out;
            for (int i = 0; i < 3; i++)
            begin
                s7_lp_reg[i] <= 48'(s6_side_reg.rel[i]) * 48'(s6_scale_reg);
            end
            s7_misc_reg  <= s6_side_reg.misc;
        end
    end

    // srgb index, linear value capped at full scale
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s8_idx[i] = (s7_lp_reg[i][47:32] != 16'h0000) ? 10'h3FF : s7_lp_reg[i][31:22];
        end
    end

    // srgb table copies
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (adv && s7_valid_reg && s7_misc_reg.srgb_we)
            begin
                srgb_mem[i][s7_misc_reg.srgb_idx] <= s7_misc_reg.srgb_val;
            end
            if (adv)
            begin
                srgb_rd_reg[i] <= srgb_mem[i][s8_idx[i]];
            end
        end
    end

    // gain divide by 100 and black for zero luma
    always_comb
    begin
        logic [33:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t = 34'(s9_gp_reg[i]) * 34'(pqtm_pkg::RECIP_100);
            if (s9_misc_reg.zero)
            begin
                s10_res_next[i] = 8'd0;
            end
            else
            begin
                s10_res_next[i] = (t[33:24] > 10'd255) ? 8'hFF : t[31:24];
            end
        end
    end

    // rec.709 luma of the encoded pixel
    always_comb
    begin
        logic [15:0] ys;
        ys = 16'(s10_res_reg[0]) * 16'd19 + 16'(s10_res_reg[1]) * 16'd183
           + 16'(s10_res_reg[2]) * 16'd54;
        s11_yl_next = ys[15:8];
    end

    // saturation products
    always_comb
    begin
        logic signed [9:0]  diff;
        logic signed [19:0] p;
        for (int i = 0; i < 3; i++)
        begin
            diff = $signed({2'b00, s11_res_reg[i]}) - $signed({2'b00, s11_yl_reg});
            p    = diff * $signed({1'b0, chroma_eff});
            s12_d_next[i] = p[17:0];
        end
    end

    // truncating divide by 100, add luma back, clamp
    always_comb
    begin
        logic              neg;
        logic [17:0]       negd;
        logic [16:0]       mag;
        logic [34:0]       t;
        logic [9:0]        qq;
        logic signed [11:0] qs;
        logic signed [11:0] v;
        for (int i = 0; i < 3; i++)
        begin
            neg  = s12_d_reg[i][17];
            negd = 18'(-s12_d_reg[i]);
            mag  = neg ? negd[16:0] : s12_d_reg[i][16:0];
            t    = 35'(mag) * 35'(pqtm_pkg::RECIP_100);
            qq   = t[33:24];
            qs   = neg ? -$signed(12'(qq)) : $signed(12'(qq));
            v    = $signed(12'(s12_yl_reg)) + qs;
            if (v < 0)
            begin
                s13_ch_next[i] = 8'd0;
            end
            else if (v > 12'sd255)
            begin
                s13_ch_next[i] = 8'hFF;
            end
            else
            begin
                s13_ch_next[i] = v[7:0];
            end
        end
    end

    // back end stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_misc_reg <= s7_misc_reg;
            for (int i = 0; i < 3; i++)
            begin
                s9_gp_reg[i] <= 16'(srgb_rd_reg[i]) * 16'(gain_eff);
            end
            s9_misc_reg <= s8_misc_reg;
            s10_res_reg <= s10_res_next;
            s10_fe_reg  <= s9_misc_reg.frame_end;
            s10_pix_reg <= s9_misc_reg.pix;
            s11_res_reg <= s10_res_reg;
            s11_yl_reg  <= s11_yl_next;
            s11_fe_reg  <= s10_fe_reg;
            s11_pix_reg <= s10_pix_reg;
            s12_d_reg   <= s12_d_next;
            s12_yl_reg  <= s11_yl_reg;
            s12_fe_reg  <= s11_fe_reg;
            s12_pix_reg <= s11_pix_reg;
            s13_sdr_reg.blue_out      <= s13_ch_next[0];
            s13_sdr_reg.green_out     <= s13_ch_next[1];
            s13_sdr_reg.red_out       <= s13_ch_next[2];
            s13_sdr_reg.frame_end_out <= s12_fe_reg;
        end
    end

    // checks
    `PQTM_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, sdr_valid && !sdr_ready, !pixel_ready)
    `PQTM_ASSERT_NEXT(a_stall_holds_front, clk, rst_n, !pixel_ready, $stable(s1_valid_reg))
    `PQTM_ASSERT_NEXT(a_load_makes_no_result, clk, rst_n, adv && s12_valid_reg && !s12_pix_reg, !sdr_valid)

endmodule
`default_nettype wire

>>> test/pq_rgb_pixel_tonemap_top_test.sv
`default_nettype none
module pq_rgb_pixel_tonemap_top_test;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    pqtm_pkg::pqtm_pixel_t pixel;
    logic                  sdr_valid;
    logic                  sdr_ready;
    pqtm_pkg::pqtm_sdr_t   sdr;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [3:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    pq_rgb_pixel_tonemap_top uut (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .sdr_valid(sdr_valid), .sdr_ready(sdr_ready), .sdr(sdr),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the tables and registers
    logic [25:0] pq_nits   [pqtm_pkg::PQ_DEPTH];
    logic [15:0] baked     [pqtm_pkg::BK_DEPTH];
    logic [7:0]  srgb_lut  [pqtm_pkg::SRGB_DEPTH];
    bit          pq_set    [pqtm_pkg::PQ_DEPTH];
    bit          baked_set [pqtm_pkg::BK_DEPTH];
    bit          srgb_set  [pqtm_pkg::SRGB_DEPTH];
    logic [6:0]  target_reg;
    logic [13:0] paper_reg;
    logic [7:0]  gain_reg;
    logic [8:0]  chroma_reg;

    pqtm_pkg::pqtm_pixel_t pending_items[$];
    pqtm_pkg::pqtm_sdr_t   expected_sdr[$];
    int          n_queued;
    int          n_accepted;
    int          n_sent;
    int          n_pixels;
    int          n_loads;
    int          n_checked;
    int          n_errors;
    int          idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned clampu(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // tonemap of one pixel from the shadow state; reports the baked and srgb entries it reads
    function automatic pqtm_pkg::pqtm_sdr_t tonemap_pixel(input logic [7:0] b, g, r,
                                                          input logic fe,
                                                          output int bk_idx,
                                                          output int sx[3]);
        longint unsigned tgt, pap, gn, chr, y, yo, yrel, scale, rel, lin, idx;
        longint unsigned nq[3];
        int res[3];
        int yl;
        pqtm_pkg::pqtm_sdr_t o;
        tgt = clampu(target_reg, 1, 100);
        pap = clampu(paper_reg, 1, 10000);
        gn  = clampu(gain_reg, 1, 200);
        chr = clampu(chroma_reg, 0, 300);
        nq[0] = pq_nits[b];
        nq[1] = pq_nits[g];
        nq[2] = pq_nits[r];
        bk_idx = -1;
        sx = '{-1, -1, -1};
        y = ((689 * nq[2] + 1778 * nq[1] + 155 * nq[0]) >> 12) >> 12;
        if (y == 0)
        begin
            res = '{0, 0, 0};
        end
        else
        begin
            if (tgt == pqtm_pkg::BAKED_TARGET && pap == pqtm_pkg::BAKED_PAPER)
            begin
                if (y > 4095) y = 4095;
                bk_idx = int'(y);
                yo = baked[y];
            end
            else
            begin
                if (y > 10000) y = 10000;
                yo = (2 * tgt * y * 65535) / (100 * (y + pap));
                if (yo > 65535) yo = 65535;
            end
            yrel = (y << 16) / pap;
            if (yrel == 0) yrel = 1;
            scale = (yo << 16) / yrel;
            if (scale > pqtm_pkg::SCALE_CAP) scale = pqtm_pkg::SCALE_CAP;
            for (int i = 0; i < 3; i++)
            begin
                rel = ((nq[i] >> 12) << 16) / pap;
                lin = (rel * scale) >> 16;
                if (lin > 65535) lin = 65535;
                idx = lin >> 6;
                if (idx > 1023) idx = 1023;
                sx[i] = int'(idx);
                res[i] = srgb_lut[idx];
                if (gn != 100)
                begin
                    res[i] = (res[i] * int'(gn)) / 100;
                    if (res[i] > 255) res[i] = 255;
                end
            end
        end
        // saturation around rec.709 luma
        if (chr != 100)
        begin
            yl = (19 * res[0] + 183 * res[1] + 54 * res[2]) >>> 8;
            for (int i = 0; i < 3; i++)
            begin
                res[i] = yl + ((res[i] - yl) * int'(chr)) / 100;
                res[i] = res[i] < 0 ? 0 : (res[i] > 255 ? 255 : res[i]);
            end
        end
        o.blue_out      = res[0][7:0];
        o.green_out     = res[1][7:0];
        o.red_out       = res[2][7:0];
        o.frame_end_out = fe;
        return o;
    endfunction

    // table load transaction, applied to the shadow tables
    task automatic queue_load(pqtm_pkg::pqtm_cmd_t c, int unsigned idx, int unsigned val);
        pqtm_pkg::pqtm_pixel_t t;
        t = $urandom;
        t.cmd = c;
        t.table_index = idx[11:0];
        t.table_value = val[25:0];
        if (c == pqtm_pkg::CMD_LOAD_PQ && idx < pqtm_pkg::PQ_DEPTH)
        begin
            pq_nits[idx] = val[25:0];
            pq_set[idx] = 1'b1;
        end
        else if (c == pqtm_pkg::CMD_LOAD_BAKED)
        begin
            baked[t.table_index] = val[15:0];
            baked_set[t.table_index] = 1'b1;
        end
        else if (c == pqtm_pkg::CMD_LOAD_SRGB && idx < pqtm_pkg::SRGB_DEPTH)
        begin
            srgb_lut[idx] = val[7:0];
            srgb_set[idx] = 1'b1;
        end
        pending_items.push_back(t);
        n_queued++;
        n_loads++;
    endtask

    function automatic int unsigned rand_nits();
        if ($urandom_range(0, 15) == 0)
            return 0;
        return $urandom_range(0, 26'h3FFFFFF) >> $urandom_range(0, 14);
    endfunction

    // pixel transaction, preceded by loads of every entry it will read that is not yet loaded
    task automatic queue_pixel(logic [7:0] b, g, r, logic fe);
        pqtm_pkg::pqtm_pixel_t t;
        pqtm_pkg::pqtm_sdr_t o;
        int bk;
        int sx[3];
        logic [7:0] codes[3];
        codes = '{b, g, r};
        foreach (codes[i])
            if (!pq_set[codes[i]])
                queue_load(pqtm_pkg::CMD_LOAD_PQ, codes[i], rand_nits());
        o = tonemap_pixel(b, g, r, fe, bk, sx);
        if (bk >= 0 && !baked_set[bk])
            queue_load(pqtm_pkg::CMD_LOAD_BAKED, bk, $urandom);
        o = tonemap_pixel(b, g, r, fe, bk, sx);
        foreach (sx[i])
            if (sx[i] >= 0 && !srgb_set[sx[i]])
                queue_load(pqtm_pkg::CMD_LOAD_SRGB, sx[i], $urandom);
        o = tonemap_pixel(b, g, r, fe, bk, sx);
        t = $urandom;
        t.cmd = pqtm_pkg::CMD_PIXEL;
        t.blue_in = b;
        t.green_in = g;
        t.red_in = r;
        t.frame_end = fe;
        pending_items.push_back(t);
        expected_sdr.push_back(o);
        n_queued++;
        n_pixels++;
    endtask

    // register write: setup cycle then access cycle
    task automatic cfg_write(logic [1:0] idx, int unsigned val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pqtm_pkg::REG_TARGET: target_reg = val[6:0];
            pqtm_pkg::REG_PAPER:  paper_reg  = val[13:0];
            pqtm_pkg::REG_GAIN:   gain_reg   = val[7:0];
            default:              chroma_reg = val[8:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || n_accepted != n_queued || expected_sdr.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random pixels, codes drawn often from a small pool so entries get reused
    task automatic random_phase(int count);
        logic [7:0] c[3];
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // noise: loads that fall outside their table
                if ($urandom_range(0, 1))
                    queue_load(pqtm_pkg::CMD_LOAD_PQ,
                               $urandom_range(pqtm_pkg::PQ_DEPTH, 4095), $urandom);
                else
                    queue_load(pqtm_pkg::CMD_LOAD_SRGB,
                               $urandom_range(pqtm_pkg::SRGB_DEPTH, 4095), $urandom);
            end
            foreach (c[i])
                c[i] = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 31));
            queue_pixel(c[0], c[1], c[2], 1'($urandom));
        end
    endtask

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || n_accepted == n_sent))
        begin
            if (gap_left > 0)
            begin
                pixel_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                pixel <= pending_items.pop_front();
                pixel_valid <= 1'b1;
                n_sent <= n_sent + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // receiver: stall pattern changes mode every so often
    int rx_mode;
    int rx_mode_left;
    int rx_stall;
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(32, 200);
        end
        else
            rx_mode_left <= rx_mode_left - 1;
        if (rx_stall > 0)
        begin
            sdr_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (rx_mode == 1)
            sdr_ready <= ($urandom_range(0, 3) != 0);
        else if (rx_mode == 2 && $urandom_range(0, 15) == 0)
        begin
            sdr_ready <= 1'b0;
            rx_stall <= $urandom_range(1, 30);
        end
        else
            sdr_ready <= 1'b1;
    end

    // monitor: count accepted transactions and check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                n_accepted <= n_accepted + 1;
            if (sdr_valid && sdr_ready)
            begin
                if (expected_sdr.size() == 0)
                begin
                    $display("%0t: unexpected sdr transaction %h", $time, sdr);
                    n_errors++;
                end
                else
                begin
                    pqtm_pkg::pqtm_sdr_t e;
                    e = expected_sdr.pop_front();
                    if (e.blue_out !== sdr.blue_out)
                        $display("%0t: blue_out expected %0d actual %0d",
                                 $time, e.blue_out, sdr.blue_out);
                    if (e.green_out !== sdr.green_out)
                        $display("%0t: green_out expected %0d actual %0d",
                                 $time, e.green_out, sdr.green_out);
                    if (e.red_out !== sdr.red_out)
                        $display("%0t: red_out expected %0d actual %0d",
                                 $time, e.red_out, sdr.red_out);
                    if (e.frame_end_out !== sdr.frame_end_out)
                        $display("%0t: frame_end_out expected %0d actual %0d",
                                 $time, e.frame_end_out, sdr.frame_end_out);
                    if (e !== sdr)
                        n_errors++;
                    n_checked++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (sdr_valid && sdr_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("pq_rgb_pixel_tonemap_top test failed");
            $finish;
        end
    end

    // phases of register settings
    int unsigned phase_cfg[8][4] = '{
        '{58, 203, 100, 100},
        '{58, 203, 150, 0},
        '{1, 1, 1, 300},
        '{100, 10000, 200, 150},
        '{0, 0, 0, 511},
        '{127, 16383, 255, 0},
        '{58, 203, 255, 100},
        '{30, 1000, 100, 120}
    };

    initial
    begin
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        sdr_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_queued = 0;
        n_accepted = 0;
        n_sent = 0;
        n_pixels = 0;
        n_loads = 0;
        n_checked = 0;
        n_errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        rx_stall = 0;
        target_reg = 7'd50;
        paper_reg = 14'd400;
        gain_reg = 8'd150;
        chroma_reg = 9'd150;
        foreach (pq_nits[i]) begin pq_nits[i] = '0; pq_set[i] = 1'b0; end
        foreach (baked[i]) begin baked[i] = '0; baked_set[i] = 1'b0; end
        foreach (srgb_lut[i]) begin srgb_lut[i] = '0; srgb_set[i] = 1'b0; end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, ignored and truncated loads, zero luma
        queue_load(pqtm_pkg::CMD_LOAD_PQ, 0, 26'h3FFFFFF);
        queue_load(pqtm_pkg::CMD_LOAD_PQ, 255, 0);
        queue_load(pqtm_pkg::CMD_LOAD_PQ, 4095, 26'h155);
        queue_load(pqtm_pkg::CMD_LOAD_SRGB, 1023, 26'h3FFFF00);
        queue_load(pqtm_pkg::CMD_LOAD_SRGB, 1024, 26'h2AAAAAA);
        queue_load(pqtm_pkg::CMD_LOAD_SRGB, 0, 26'h1FF);
        queue_load(pqtm_pkg::CMD_LOAD_BAKED, 4095, 26'h3FFFFFF);
        queue_load(pqtm_pkg::CMD_LOAD_PQ, 1, 26'h0001000);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        queue_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        queue_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        queue_pixel(8'd1, 8'd1, 8'd1, 1'b1);
        queue_pixel(8'd170, 8'd85, 8'd1, 1'b0);
        random_phase(40);
        wait_idle();

        foreach (phase_cfg[p])
        begin
            cfg_write(pqtm_pkg::REG_TARGET, phase_cfg[p][0]);
            cfg_write(pqtm_pkg::REG_PAPER, phase_cfg[p][1]);
            cfg_write(pqtm_pkg::REG_GAIN, phase_cfg[p][2]);
            cfg_write(pqtm_pkg::REG_CHROMA, phase_cfg[p][3]);
            random_phase(p == 0 ? 60 : 35);
            wait_idle();
        end

        $display("covered %0d of %0d pixels checked and %0d table loads over %0d settings",
                 n_checked, n_pixels, n_loads, 9);
        if (n_errors == 0 && expected_sdr.size() == 0)
            $display("pq_rgb_pixel_tonemap_top test passed");
        else
            $display("pq_rgb_pixel_tonemap_top test failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> pq_rgb_pixel_tonemap_top.f
+incdir+src
src/pqtm_pkg.sv
src/pqtm_div_pipe.sv
src/pq_rgb_pixel_tonemap_top.sv
test/pq_rgb_pixel_tonemap_top_test.sv
